// File: hw/rtl/text_console_writer_top_assert.svh
// Assertion macros for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcw assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcw assertion failed");

// Condition must never be true.
`define TCW_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) 1'b1 |-> !(cond)) \
      else $error("tcw assertion failed");

`else

`define TCW_ASSERT_IMP(label, clk, rst, ante, cons)
`define TCW_ASSERT_NXT(label, clk, rst, ante, cons)
`define TCW_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// File: hw/rtl/tcw_pkg.sv
// Shared types, constants and helpers for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

   // Fixed port widths
   localparam int CHAR_W          = 8;
   localparam int READ_ROW_W      = 5;
   localparam int READ_COL_W      = 7;
   localparam int CURSOR_ROW_W    = 5;
   localparam int CURSOR_COL_W    = 7;
   localparam int CURSOR_OFFSET_W = 11;

   // Defaults for the top-level parameters
   localparam int DEFAULT_COLUMNS     = 80;
   localparam int DEFAULT_ROWS        = 25;
   localparam int DEFAULT_TAB_WIDTH   = 8;
   localparam int DEFAULT_QUEUE_DEPTH = 4;

   // Transaction kinds
   localparam logic KIND_PUT  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // Control characters and cell contents
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
   localparam logic [CHAR_W-1:0] TEXT_ATTR      = 8'h07;

   typedef enum logic [2:0] {
      CLS_PRINT,
      CLS_NEWLINE,
      CLS_TAB,
      CLS_BACKSPACE,
      CLS_RETURN
   } char_class_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_WRITE,
      CMD_READ
   } cmd_op_type;

   typedef enum logic [1:0] {
      BK_INIT,
      BK_IDLE,
      BK_CLEAR,
      BK_READ
   } back_state_type;

   typedef struct packed {
      logic [CURSOR_ROW_W-1:0]    cursor_row;
      logic [CURSOR_COL_W-1:0]    cursor_col;
      logic [CURSOR_OFFSET_W-1:0] cursor_offset;
      logic [CHAR_W-1:0]          cell_char;
      logic [CHAR_W-1:0]          cell_attr;
      logic                       drop_key;
   } rsp_type;

   // Work for the back end: optional cell write or cell read, then optional scroll
   typedef struct packed {
      cmd_op_type        op;
      logic              scroll;
      logic [CHAR_W-1:0] char_code;
      rsp_type           rsp;
   } cmd_type;

   function automatic char_class_type classify(input logic [CHAR_W-1:0] ch);
      char_class_type cls;
      cls = CLS_PRINT;
      if (ch == CHAR_NEWLINE) begin
         cls = CLS_NEWLINE;
      end else if (ch == CHAR_TAB) begin
         cls = CLS_TAB;
      end else if (ch == CHAR_BACKSPACE) begin
         cls = CLS_BACKSPACE;
      end else if (ch == CHAR_RETURN) begin
         cls = CLS_RETURN;
      end
      return cls;
   endfunction

endpackage

// File: hw/rtl/tcw_queue.sv
// Small FIFO between the console front end and back end.
`timescale 1ns / 1ps

module tcw_queue
   import tcw_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: hw/rtl/tcw_front.sv
// Front end: accepts transactions, tracks the cursor, issues cell commands.
`timescale 1ns / 1ps

module tcw_front
   import tcw_pkg::*;
#(
   parameter int COLUMNS   = DEFAULT_COLUMNS,
   parameter int ROWS      = DEFAULT_ROWS,
   parameter int TAB_WIDTH = DEFAULT_TAB_WIDTH,
   localparam int RW       = $clog2(ROWS),
   localparam int CW       = $clog2(COLUMNS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_kind,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic                  req_key_buffer_nonempty,
   input  logic [READ_ROW_W-1:0] req_read_row,
   input  logic [READ_COL_W-1:0] req_read_col,
   input  logic                  queue_full,
   input  logic                  back_busy,
   output logic                  cmd_push,
   output cmd_type               cmd,
   output logic [RW-1:0]         cmd_row,
   output logic [CW-1:0]         cmd_col
);

   localparam int TW  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
   localparam int TCW = $clog2(COLUMNS + TAB_WIDTH);
   localparam int OFW = $clog2(ROWS * COLUMNS);
   localparam logic [TW-1:0] LAST_PHASE = TW'((COLUMNS - 1) % TAB_WIDTH);

   logic [RW-1:0]  cur_row_ff, cur_row_in;
   logic [CW-1:0]  cur_col_ff, cur_col_in;
   logic [TW-1:0]  phase_ff, phase_in;   // cursor column modulo tab width
   logic           accept;
   char_class_type cls;
   logic [TCW-1:0] tab_col;
   logic [OFW-1:0] offset;

   assign full     = queue_full || back_busy;
   assign accept   = push && !full;
   assign cmd_push = accept;
   assign cls      = classify(req_char_code);
   assign tab_col  = TCW'(cur_col_ff) + TCW'(TAB_WIDTH) - TCW'(phase_ff);

   // Cursor update and command decode
   always_comb begin
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      phase_in      = phase_ff;
      cmd.op        = CMD_NONE;
      cmd.scroll    = 1'b0;
      cmd.char_code = req_char_code;
      cmd_row       = cur_row_ff;
      cmd_col       = cur_col_ff;
      cmd.rsp.drop_key  = 1'b0;
      cmd.rsp.cell_char = '0;
      cmd.rsp.cell_attr = '0;
      if (req_kind == KIND_READ) begin
         if (req_read_row < ROWS && req_read_col < COLUMNS) begin
            cmd.op  = CMD_READ;
            cmd_row = RW'(req_read_row);
            cmd_col = CW'(req_read_col);
         end
      end else begin
         unique case (cls)
            CLS_NEWLINE: begin
               cur_col_in = '0;
               phase_in   = '0;
               if (cur_row_ff == RW'(ROWS - 1)) begin
                  cmd.scroll = 1'b1;
               end else begin
                  cur_row_in = cur_row_ff + 1'b1;
               end
            end
            CLS_TAB: begin
               if (tab_col > TCW'(COLUMNS - 1)) begin
                  cur_col_in = '0;
                  phase_in   = '0;
                  if (cur_row_ff == RW'(ROWS - 1)) begin
                     cmd.scroll = 1'b1;
                  end else begin
                     cur_row_in = cur_row_ff + 1'b1;
                  end
               end else begin
                  cur_col_in = CW'(tab_col);
                  phase_in   = '0;
               end
            end
            CLS_BACKSPACE: begin
               if (req_key_buffer_nonempty) begin
                  cmd.rsp.drop_key = 1'b1;
                  cmd.op           = CMD_WRITE;
                  cmd.char_code    = BLANK_CHAR;
                  if (cur_col_ff != '0) begin
                     cur_col_in = cur_col_ff - 1'b1;
                     phase_in   = (phase_ff == '0) ? TW'(TAB_WIDTH - 1) : phase_ff - 1'b1;
                  end else if (cur_row_ff != '0) begin
                     cur_col_in = CW'(COLUMNS - 1);
                     phase_in   = LAST_PHASE;
                     cur_row_in = cur_row_ff - 1'b1;
                  end
                  // blank the cell at the new cursor
                  cmd_row = cur_row_in;
                  cmd_col = cur_col_in;
               end
            end
            CLS_RETURN: begin
               cur_col_in = '0;
               phase_in   = '0;
            end
            CLS_PRINT: begin
               cmd.op = CMD_WRITE;
               if (cur_col_ff == CW'(COLUMNS - 1)) begin
                  cur_col_in = '0;
                  phase_in   = '0;
                  if (cur_row_ff == RW'(ROWS - 1)) begin
                     cmd.scroll = 1'b1;
                  end else begin
                     cur_row_in = cur_row_ff + 1'b1;
                  end
               end else begin
                  cur_col_in = cur_col_ff + 1'b1;
                  phase_in   = (phase_ff == TW'(TAB_WIDTH - 1)) ? '0 : phase_ff + 1'b1;
               end
            end
            default: begin
               cmd.op = CMD_NONE;
            end
         endcase
      end
      offset = OFW'(cur_row_in) * OFW'(COLUMNS) + OFW'(cur_col_in);
      cmd.rsp.cursor_row    = CURSOR_ROW_W'(cur_row_in);
      cmd.rsp.cursor_col    = CURSOR_COL_W'(cur_col_in);
      cmd.rsp.cursor_offset = CURSOR_OFFSET_W'(offset);
   end

   // Cursor registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         phase_ff   <= '0;
      end else if (accept) begin
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         phase_ff   <= phase_in;
      end
   end

endmodule

// File: hw/rtl/tcw_back.sv
// Back end: screen memory, rotating top row, row clearing and result register.
`timescale 1ns / 1ps
`include "text_console_writer_top_assert.svh"

module tcw_back
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEFAULT_COLUMNS,
   parameter int ROWS    = DEFAULT_ROWS,
   localparam int RW     = $clog2(ROWS),
   localparam int CW     = $clog2(COLUMNS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_empty,
   output logic                       cmd_pop,
   input  cmd_type                    cmd,
   input  logic [RW-1:0]              cmd_row,
   input  logic [CW-1:0]              cmd_col,
   output logic                       busy,
   input  logic                       pop,
   output logic                       empty,
   output logic [CURSOR_ROW_W-1:0]    rsp_cursor_row,
   output logic [CURSOR_COL_W-1:0]    rsp_cursor_col,
   output logic [CURSOR_OFFSET_W-1:0] rsp_cursor_offset,
   output logic [CHAR_W-1:0]          rsp_cell_char,
   output logic [CHAR_W-1:0]          rsp_cell_attr,
   output logic                       rsp_drop_key
);

   localparam int AW    = RW + CW;
   localparam int DEPTH = ROWS * (2 ** CW);

   // Attribute is always the text attribute, so only the character is stored
   logic [CHAR_W-1:0] screen_ff [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   back_state_type state_ff, state_in;
   logic [RW-1:0]  top_ff, top_in;
   logic [RW-1:0]  sweep_row_ff, sweep_row_in;
   logic [CW-1:0]  sweep_col_ff, sweep_col_in;
   rsp_type        rsp_ff, rsp_in;
   rsp_type        hold_rsp_ff, hold_rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic              rsp_pop, slot_free, issue;
   logic              rsp_load;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [CHAR_W-1:0] mem_wdata;
   logic [RW:0]       phys_sum;
   logic [RW-1:0]     phys_row;
   logic              sweep_last_col, sweep_last_row;

   assign rsp_pop        = pop && rsp_valid_ff;
   assign slot_free      = !rsp_valid_ff || rsp_pop;
   assign issue          = (state_ff == BK_IDLE) && !cmd_empty && slot_free;
   assign sweep_last_col = (sweep_col_ff == CW'(COLUMNS - 1));
   assign sweep_last_row = (sweep_row_ff == RW'(ROWS - 1));
   assign busy           = (state_ff == BK_INIT);
   assign empty          = !rsp_valid_ff;

   // Logical row to physical row through the rotating top pointer
   always_comb begin
      phys_sum = {1'b0, top_ff} + {1'b0, cmd_row};
      if (phys_sum >= (RW + 1)'(ROWS)) begin
         phys_sum = phys_sum - (RW + 1)'(ROWS);
      end
      phys_row = phys_sum[RW-1:0];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_INIT: begin
            if (sweep_last_col && sweep_last_row) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (issue) begin
               if (cmd.op == CMD_READ) begin
                  state_in = BK_READ;
               end else if (cmd.scroll) begin
                  state_in = BK_CLEAR;
               end
            end
         end
         BK_CLEAR: begin
            if (sweep_last_col) begin
               state_in = BK_IDLE;
            end
         end
         BK_READ: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // State outputs and datapath controls
   always_comb begin
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = {sweep_row_ff, sweep_col_ff};
      mem_raddr    = {phys_row, cmd_col};
      mem_wdata    = BLANK_CHAR;
      rsp_load     = 1'b0;
      rsp_in       = cmd.rsp;
      hold_rsp_in  = hold_rsp_ff;
      top_in       = top_ff;
      sweep_row_in = sweep_row_ff;
      sweep_col_in = sweep_col_ff;
      unique case (state_ff)
         BK_INIT: begin
            mem_we       = 1'b1;
            sweep_col_in = sweep_last_col ? '0 : sweep_col_ff + 1'b1;
            if (sweep_last_col) begin
               sweep_row_in = sweep_last_row ? '0 : sweep_row_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            if (issue) begin
               cmd_pop = 1'b1;
               if (cmd.op == CMD_READ) begin
                  mem_re      = 1'b1;
                  hold_rsp_in = cmd.rsp;
               end else begin
                  rsp_load = 1'b1;
                  if (cmd.op == CMD_WRITE) begin
                     mem_we    = 1'b1;
                     mem_waddr = {phys_row, cmd_col};
                     mem_wdata = cmd.char_code;
                  end
                  // old top row becomes the new bottom row and is blanked
                  if (cmd.scroll) begin
                     top_in       = (top_ff == RW'(ROWS - 1)) ? '0 : top_ff + 1'b1;
                     sweep_row_in = top_ff;
                     sweep_col_in = '0;
                  end
               end
            end
         end
         BK_CLEAR: begin
            mem_we       = 1'b1;
            sweep_col_in = sweep_last_col ? '0 : sweep_col_ff + 1'b1;
         end
         BK_READ: begin
            rsp_load         = 1'b1;
            rsp_in           = hold_rsp_ff;
            rsp_in.cell_char = rd_data_ff;
            rsp_in.cell_attr = TEXT_ATTR;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_pop ? 1'b0 : rsp_valid_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_INIT;
         top_ff       <= '0;
         sweep_row_ff <= '0;
         sweep_col_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         sweep_row_ff <= sweep_row_in;
         sweep_col_ff <= sweep_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hold_rsp_ff <= hold_rsp_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Screen memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= screen_ff[mem_raddr];
      end
   end

   assign rsp_cursor_row    = rsp_ff.cursor_row;
   assign rsp_cursor_col    = rsp_ff.cursor_col;
   assign rsp_cursor_offset = rsp_ff.cursor_offset;
   assign rsp_cell_char     = rsp_ff.cell_char;
   assign rsp_cell_attr     = rsp_ff.cell_attr;
   assign rsp_drop_key      = rsp_ff.drop_key;

   `TCW_ASSERT_NEVER(a_pop_when_empty, clock, reset, cmd_pop && cmd_empty)
   `TCW_ASSERT_NEVER(a_rsp_overrun, clock, reset, rsp_load && rsp_valid_ff && !rsp_pop)
   `TCW_ASSERT_NXT(a_read_completes, clock, reset, state_ff == BK_READ, rsp_valid_ff)
   `TCW_ASSERT_IMP(a_top_in_range, clock, reset, 1'b1, top_ff <= RW'(ROWS - 1))
   `TCW_ASSERT_NEVER(a_no_cmd_in_init, clock, reset, (state_ff == BK_INIT) && cmd_pop)

endmodule

// File: hw/rtl/text_console_writer_top.sv
// Text console writer: top level joining front end, command queue and back end.
//
// Text-mode console of ROWS x COLUMNS character cells with a cursor. After
// reset the block holds full high while all ROWS*COLUMNS cells (2000 at the
// defaults) of the screen memory are swept to blank. The front end takes
// one transaction per cycle while full is low into a QUEUE_DEPTH-entry
// command queue; the back end, which owns the single-write/single-read
// screen memory, retires a put as it pops it and a read after the
// registered memory read, in state BK_READ. A put that scrolls moves the
// rotating top-row pointer as it is popped and then blanks the new bottom
// row, one cell per cycle, during which queued commands wait. Results come
// from an output register, so a finished result may sit there while new
// transactions are taken.
`timescale 1ns / 1ps

module text_console_writer_top
   import tcw_pkg::*;
#(
   parameter int COLUMNS     = DEFAULT_COLUMNS,
   parameter int ROWS        = DEFAULT_ROWS,
   parameter int TAB_WIDTH   = DEFAULT_TAB_WIDTH,
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic                       req_kind,
   input  logic [CHAR_W-1:0]          req_char_code,
   input  logic                       req_key_buffer_nonempty,
   input  logic [READ_ROW_W-1:0]      req_read_row,
   input  logic [READ_COL_W-1:0]      req_read_col,
   input  logic                       pop,
   output logic                       empty,
   output logic [CURSOR_ROW_W-1:0]    rsp_cursor_row,
   output logic [CURSOR_COL_W-1:0]    rsp_cursor_col,
   output logic [CURSOR_OFFSET_W-1:0] rsp_cursor_offset,
   output logic [CHAR_W-1:0]          rsp_cell_char,
   output logic [CHAR_W-1:0]          rsp_cell_attr,
   output logic                       rsp_drop_key
);

   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int CMD_W = $bits(cmd_type) + RW + CW;

   cmd_type          f_cmd, b_cmd;
   logic [RW-1:0]    f_row, b_row;
   logic [CW-1:0]    f_col, b_col;
   logic             q_push, q_full, q_pop, q_empty;
   logic [CMD_W-1:0] q_wdata, q_rdata;
   logic             back_busy;

   tcw_front #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_front (
      .clock                   (clock),
      .reset                   (reset),
      .push                    (push),
      .full                    (full),
      .req_kind                (req_kind),
      .req_char_code           (req_char_code),
      .req_key_buffer_nonempty (req_key_buffer_nonempty),
      .req_read_row            (req_read_row),
      .req_read_col            (req_read_col),
      .queue_full              (q_full),
      .back_busy               (back_busy),
      .cmd_push                (q_push),
      .cmd                     (f_cmd),
      .cmd_row                 (f_row),
      .cmd_col                 (f_col)
   );

   assign q_wdata = {f_cmd, f_row, f_col};

   tcw_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign {b_cmd, b_row, b_col} = q_rdata;

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_empty         (q_empty),
      .cmd_pop           (q_pop),
      .cmd               (b_cmd),
      .cmd_row           (b_row),
      .cmd_col           (b_col),
      .busy              (back_busy),
      .pop               (pop),
      .empty             (empty),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_offset (rsp_cursor_offset),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_attr     (rsp_cell_attr),
      .rsp_drop_key      (rsp_drop_key)
   );

endmodule

// File: tb/text_console_writer_checker.sv
// Checker for the text console writer: tracks screen and cursor, compares every result.
`timescale 1ns / 1ps

module text_console_writer_checker
   import tcw_pkg::*;
#(
   parameter int COLUMNS   = DEFAULT_COLUMNS,
   parameter int ROWS      = DEFAULT_ROWS,
   parameter int TAB_WIDTH = DEFAULT_TAB_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic                       full,
   input  logic                       req_kind,
   input  logic [CHAR_W-1:0]          req_char_code,
   input  logic                       req_key_buffer_nonempty,
   input  logic [READ_ROW_W-1:0]      req_read_row,
   input  logic [READ_COL_W-1:0]      req_read_col,
   input  logic                       pop,
   input  logic                       empty,
   input  logic [CURSOR_ROW_W-1:0]    rsp_cursor_row,
   input  logic [CURSOR_COL_W-1:0]    rsp_cursor_col,
   input  logic [CURSOR_OFFSET_W-1:0] rsp_cursor_offset,
   input  logic [CHAR_W-1:0]          rsp_cell_char,
   input  logic [CHAR_W-1:0]          rsp_cell_attr,
   input  logic                       rsp_drop_key,
   output int                         failures,
   output int                         pending
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam logic [15:0] BLANK_CELL = {TEXT_ATTR, BLANK_CHAR};

   // Shadow of the screen memory and cursor
   logic [15:0] screen_mem [CELL_COUNT];
   int unsigned cur_row;
   int unsigned cur_col;

   // Expected results, oldest first
   rsp_type expected_rsp_q[$];

   task automatic report_mismatch(input string msg);
      failures++;
      $display("[%0t] ERROR: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      end
   endtask

   function automatic void clear_screen();
      for (int i = 0; i < CELL_COUNT; i++) begin
         screen_mem[i] = BLANK_CELL;
      end
   endfunction

   // Newline: column 0 of next row, scroll up when already on the bottom row
   function automatic void advance_line();
      cur_col = 0;
      if (cur_row >= ROWS - 1) begin
         for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
            screen_mem[i] = screen_mem[i + COLUMNS];
         end
         for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
            screen_mem[i] = BLANK_CELL;
         end
      end else begin
         cur_row++;
      end
   endfunction

   // Apply one transaction to the shadow state and build its result
   function automatic rsp_type console_step(input logic kind, input logic [CHAR_W-1:0] ch,
                                            input logic keyed,
                                            input logic [READ_ROW_W-1:0] rrow,
                                            input logic [READ_COL_W-1:0] rcol);
      rsp_type r;
      int unsigned pos;
      r = '0;
      if (kind == KIND_READ) begin
         if (rrow < ROWS && rcol < COLUMNS) begin
            pos = rrow * COLUMNS + rcol;
            r.cell_char = screen_mem[pos][7:0];
            r.cell_attr = screen_mem[pos][15:8];
         end
      end else begin
         case (ch)
            CHAR_NEWLINE: begin
               advance_line();
            end
            CHAR_TAB: begin
               cur_col = TAB_WIDTH * ((cur_col / TAB_WIDTH) + 1);
               if (cur_col > COLUMNS - 1) begin
                  advance_line();
               end
            end
            CHAR_BACKSPACE: begin
               if (keyed) begin
                  r.drop_key = 1'b1;
                  if (cur_col > 0) begin
                     cur_col--;
                  end else if (cur_row > 0) begin
                     cur_col = COLUMNS - 1;
                     cur_row--;
                  end
                  screen_mem[cur_row * COLUMNS + cur_col] = BLANK_CELL;
               end
            end
            CHAR_RETURN: begin
               cur_col = 0;
            end
            default: begin
               screen_mem[cur_row * COLUMNS + cur_col] = {TEXT_ATTR, ch};
               if (cur_col >= COLUMNS - 1) begin
                  advance_line();
               end else begin
                  cur_col++;
               end
            end
         endcase
      end
      r.cursor_row    = cur_row[CURSOR_ROW_W-1:0];
      r.cursor_col    = cur_col[CURSOR_COL_W-1:0];
      r.cursor_offset = CURSOR_OFFSET_W'(cur_row * COLUMNS + cur_col);
      return r;
   endfunction

   // Watch both channels; compare first, since a transaction never
   // completes at the edge where it is accepted
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_screen();
         cur_row = 0;
         cur_col = 0;
         expected_rsp_q.delete();
         failures = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("result with no transaction outstanding");
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("cursor_row", 16'(rsp_cursor_row), 16'(want.cursor_row));
               check_field("cursor_col", 16'(rsp_cursor_col), 16'(want.cursor_col));
               check_field("cursor_offset", 16'(rsp_cursor_offset),
                           16'(want.cursor_offset));
               check_field("cell_char", 16'(rsp_cell_char), 16'(want.cell_char));
               check_field("cell_attr", 16'(rsp_cell_attr), 16'(want.cell_attr));
               check_field("drop_key", 16'(rsp_drop_key), 16'(want.drop_key));
            end
         end
         if (push && !full) begin
            expected_rsp_q.push_back(console_step(req_kind, req_char_code,
                                                  req_key_buffer_nonempty,
                                                  req_read_row, req_read_col));
         end
      end
      pending = expected_rsp_q.size();
   end

endmodule

// File: tb/tb_text_console_writer_top.sv
// Testbench top for the text console writer: stimulus, result drain and verdict.
`timescale 1ns / 1ps

module tb_text_console_writer_top;
   import tcw_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 800;
   localparam int MAX_GAP       = 13;
   localparam int SETTLE_CYCLES = 200;

   logic                       clock;
   logic                       reset;
   logic                       push;
   logic                       full;
   logic                       req_kind;
   logic [CHAR_W-1:0]          req_char_code;
   logic                       req_key_buffer_nonempty;
   logic [READ_ROW_W-1:0]      req_read_row;
   logic [READ_COL_W-1:0]      req_read_col;
   logic                       pop;
   logic                       empty;
   logic [CURSOR_ROW_W-1:0]    rsp_cursor_row;
   logic [CURSOR_COL_W-1:0]    rsp_cursor_col;
   logic [CURSOR_OFFSET_W-1:0] rsp_cursor_offset;
   logic [CHAR_W-1:0]          rsp_cell_char;
   logic [CHAR_W-1:0]          rsp_cell_attr;
   logic                       rsp_drop_key;

   int          failures;
   int          pending;
   int unsigned cycle_count = 0;
   bit          push_steady = 1'b0;
   bit          pop_steady  = 1'b0;

   text_console_writer_top u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .push                    (push),
      .full                    (full),
      .req_kind                (req_kind),
      .req_char_code           (req_char_code),
      .req_key_buffer_nonempty (req_key_buffer_nonempty),
      .req_read_row            (req_read_row),
      .req_read_col            (req_read_col),
      .pop                     (pop),
      .empty                   (empty),
      .rsp_cursor_row          (rsp_cursor_row),
      .rsp_cursor_col          (rsp_cursor_col),
      .rsp_cursor_offset       (rsp_cursor_offset),
      .rsp_cell_char           (rsp_cell_char),
      .rsp_cell_attr           (rsp_cell_attr),
      .rsp_drop_key            (rsp_drop_key)
   );

   text_console_writer_checker u_checker (
      .clock                   (clock),
      .reset                   (reset),
      .push                    (push),
      .full                    (full),
      .req_kind                (req_kind),
      .req_char_code           (req_char_code),
      .req_key_buffer_nonempty (req_key_buffer_nonempty),
      .req_read_row            (req_read_row),
      .req_read_col            (req_read_col),
      .pop                     (pop),
      .empty                   (empty),
      .rsp_cursor_row          (rsp_cursor_row),
      .rsp_cursor_col          (rsp_cursor_col),
      .rsp_cursor_offset       (rsp_cursor_offset),
      .rsp_cell_char           (rsp_cell_char),
      .rsp_cell_attr           (rsp_cell_attr),
      .rsp_drop_key            (rsp_drop_key),
      .failures                (failures),
      .pending                 (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offer one transaction after a random gap (none when push_steady); returns at the falling
   // edge that follows its acceptance
   task automatic send_item(input logic kind, input logic [CHAR_W-1:0] ch,
                            input logic keyed, input logic [READ_ROW_W-1:0] rrow,
                            input logic [READ_COL_W-1:0] rcol);
      int gap;
      gap = push_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push                    <= 1'b1;
      req_kind                <= kind;
      req_char_code           <= ch;
      req_key_buffer_nonempty <= keyed;
      req_read_row            <= rrow;
      req_read_col            <= rcol;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   // Put with junk on the unused read fields
   task automatic put_char(input logic [CHAR_W-1:0] ch, input logic keyed);
      send_item(KIND_PUT, ch, keyed, READ_ROW_W'($urandom), READ_COL_W'($urandom));
   endtask

   task automatic read_cell(input logic [READ_ROW_W-1:0] rrow,
                            input logic [READ_COL_W-1:0] rcol);
      send_item(KIND_READ, CHAR_W'($urandom), 1'($urandom), rrow, rcol);
   endtask

   // Mostly puts so the cursor wraps and scrolls; reads lean toward the bottom rows
   task automatic random_item();
      int                    pick;
      int                    sel;
      logic [CHAR_W-1:0]     ch;
      logic [READ_ROW_W-1:0] rrow;
      logic [READ_COL_W-1:0] rcol;
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 9);
      if (sel == 0) begin
         rrow = READ_ROW_W'($urandom_range(0, 31));
      end else if (sel <= 5) begin
         rrow = READ_ROW_W'($urandom_range(DEFAULT_ROWS - 5, DEFAULT_ROWS - 1));
      end else begin
         rrow = READ_ROW_W'($urandom_range(0, DEFAULT_ROWS - 1));
      end
      if ($urandom_range(0, 9) == 0) begin
         rcol = READ_COL_W'($urandom_range(0, 127));
      end else begin
         rcol = READ_COL_W'($urandom_range(0, DEFAULT_COLUMNS - 1));
      end
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         ch = CHAR_W'($urandom_range(0, 255));
      end else if (sel < 62) begin
         ch = CHAR_NEWLINE;
      end else if (sel < 70) begin
         ch = CHAR_TAB;
      end else if (sel < 82) begin
         ch = CHAR_BACKSPACE;
      end else if (sel < 88) begin
         ch = CHAR_RETURN;
      end else begin
         ch = CHAR_W'($urandom_range(8'h21, 8'h7e));
      end
      send_item(pick < 25 ? KIND_READ : KIND_PUT, ch, $urandom_range(0, 3) != 0,
                rrow, rcol);
   endtask

   // Result side: random stall per transaction, with stall-free stretches
   initial begin : result_drain
      int          gap;
      int unsigned taken;
      pop   = 1'b0;
      taken = 0;
      @(negedge clock);
      forever begin
         if (taken % 50 == 0) begin
            pop_steady = ($urandom_range(0, 3) == 0);
         end
         gap = pop_steady ? 0 : $urandom_range(0, MAX_GAP);
         if (gap != 0) begin
            pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty || reset);
         @(negedge clock);
         taken++;
      end
   end

   // Stimulus and verdict
   initial begin
      reset                   = 1'b1;
      push                    = 1'b0;
      req_kind                = KIND_PUT;
      req_char_code           = '0;
      req_key_buffer_nonempty = 1'b0;
      req_read_row            = '0;
      req_read_col            = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Backspace at the home position, then with an empty key buffer
      put_char(CHAR_BACKSPACE, 1'b1);
      put_char(CHAR_BACKSPACE, 1'b0);
      // Byte extremes and a plain letter
      put_char(8'h00, 1'b0);
      put_char(8'hff, 1'b1);
      put_char(8'h41, 1'b0);
      read_cell(READ_ROW_W'(0), READ_COL_W'(1));
      // Tabs run across the line; the last tab stop past the end acts as newline
      repeat (10) put_char(CHAR_TAB, 1'b0);
      // Backspace at column 0 climbs to the end of the row above
      put_char(CHAR_BACKSPACE, 1'b1);
      // Write in the last column wraps to the next line
      put_char(8'h5a, 1'b0);
      put_char(8'h78, 1'b1);
      put_char(CHAR_RETURN, 1'b0);
      // Corner cells and out-of-range reads
      read_cell(READ_ROW_W'(0), READ_COL_W'(0));
      read_cell(READ_ROW_W'(0), READ_COL_W'(DEFAULT_COLUMNS - 1));
      read_cell(READ_ROW_W'(DEFAULT_ROWS - 1), READ_COL_W'(DEFAULT_COLUMNS - 1));
      read_cell(READ_ROW_W'(DEFAULT_ROWS), READ_COL_W'(0));
      read_cell(READ_ROW_W'(0), READ_COL_W'(DEFAULT_COLUMNS));
      read_cell(READ_ROW_W'(31), READ_COL_W'(127));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            push_steady = ($urandom_range(0, 3) == 0);
         end
         random_item();
      end
      push <= 1'b0;

      // Drain, then leave time for any stray result
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
